### rtl/core/chat_message_deframer_defines.svh
// ----------------------------------------------------------------------------
// Chat message deframer assertion macros
// Shared assertion forms for the chat message deframer. Each one is clocked on
// the rising edge and held off while reset is active.
// ----------------------------------------------------------------------------
`ifndef CHAT_MESSAGE_DEFRAMER_DEFINES_SVH
`define CHAT_MESSAGE_DEFRAMER_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define CMDF_ASSERT(label, clk, rstn, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// The consequent must hold at every edge at which the antecedent holds.
`define CMDF_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

`endif

### rtl/core/cmdf_pkg.sv
// ----------------------------------------------------------------------------
// Chat message deframer package
// Message type codes, byte role codes and the result type shared by the
// deframer modules.
// ----------------------------------------------------------------------------
package cmdf_pkg;

  localparam logic [7:0] KIND_BYE     = 8'd0;
  localparam logic [7:0] KIND_HELLO   = 8'd2;
  localparam logic [7:0] KIND_WELCOME = 8'd3;
  localparam logic [7:0] KIND_CHAT    = 8'd4;

  localparam logic [3:0] ROLE_TYPE     = 4'd0;
  localparam logic [3:0] ROLE_NAME_LEN = 4'd1;
  localparam logic [3:0] ROLE_TLEN_HI  = 4'd2;
  localparam logic [3:0] ROLE_TLEN_LO  = 4'd3;
  localparam logic [3:0] ROLE_NAME     = 4'd4;
  localparam logic [3:0] ROLE_TEXT     = 4'd5;
  localparam logic [3:0] ROLE_REASON   = 4'd6;
  localparam logic [3:0] ROLE_MAX_NAME = 4'd7;
  localparam logic [3:0] ROLE_MAX_HI   = 4'd8;
  localparam logic [3:0] ROLE_MAX_LO   = 4'd9;
  localparam logic [3:0] ROLE_UNKNOWN  = 4'd10;

  typedef struct packed {
    logic [3:0]  byte_role;
    logic [7:0]  byte_value;
    logic [7:0]  frame_kind;
    logic [15:0] field_offset;
    logic        frame_end;
  } result_t;

endpackage

### rtl/core/cmdf_in_stage.sv
// ----------------------------------------------------------------------------
// Chat message deframer input stage
// Registers each incoming byte and holds it until the parser consumes it.
// ----------------------------------------------------------------------------
module cmdf_in_stage
  import cmdf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] stream_byte_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= stream_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

### rtl/core/cmdf_parser.sv
// ----------------------------------------------------------------------------
// Chat message deframer parser
// Holds the frame parsing state and tags the registered byte with its role,
// frame type, field offset and frame end flag.
// ----------------------------------------------------------------------------
module cmdf_parser
  import cmdf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  output result_t    result_o
);

  localparam logic [3:0] PH_TYPE    = 4'd0;
  localparam logic [3:0] PH_REASON  = 4'd1;
  localparam logic [3:0] PH_NAMELEN = 4'd2;
  localparam logic [3:0] PH_TLENHI  = 4'd3;
  localparam logic [3:0] PH_TLENLO  = 4'd4;
  localparam logic [3:0] PH_NAME    = 4'd5;
  localparam logic [3:0] PH_TEXT    = 4'd6;
  localparam logic [3:0] PH_MAXNAME = 4'd7;
  localparam logic [3:0] PH_MAXHI   = 4'd8;
  localparam logic [3:0] PH_MAXLO   = 4'd9;

  logic [3:0]  phase_q, phase_d;
  logic [7:0]  kind_q, kind_d;
  logic [7:0]  name_len_q, name_len_d;
  logic [15:0] text_len_q, text_len_d;
  logic [15:0] pos_q, pos_d;
  logic [15:0] pos_inc;
  logic [3:0]  role;
  logic [15:0] offset;
  logic        frame_end;

  assign pos_inc = pos_q + 16'd1;

  always_comb begin
    phase_d    = phase_q;
    kind_d     = kind_q;
    name_len_d = name_len_q;
    text_len_d = text_len_q;
    pos_d      = pos_q;
    role       = ROLE_TYPE;
    offset     = 16'd0;
    frame_end  = 1'b0;
    case (phase_q)
      PH_REASON: begin
        role      = ROLE_REASON;
        frame_end = 1'b1;
        phase_d   = PH_TYPE;
      end
      PH_NAMELEN: begin
        role       = ROLE_NAME_LEN;
        name_len_d = byte_i;
        pos_d      = 16'd0;
        if (kind_q == KIND_CHAT) begin
          phase_d = PH_TLENHI;
        end else if (byte_i == 8'd0) begin
          frame_end = 1'b1;
          phase_d   = PH_TYPE;
        end else begin
          phase_d = PH_NAME;
        end
      end
      PH_TLENHI: begin
        role       = ROLE_TLEN_HI;
        text_len_d = {byte_i, 8'd0};
        phase_d    = PH_TLENLO;
      end
      PH_TLENLO: begin
        role       = ROLE_TLEN_LO;
        text_len_d = text_len_q | {8'd0, byte_i};
        pos_d      = 16'd0;
        if (name_len_q != 8'd0) begin
          phase_d = PH_NAME;
        end else if (text_len_d != 16'd0) begin
          phase_d = PH_TEXT;
        end else begin
          frame_end = 1'b1;
          phase_d   = PH_TYPE;
        end
      end
      PH_NAME: begin
        role   = ROLE_NAME;
        offset = pos_q;
        pos_d  = pos_inc;
        if (pos_inc >= {8'd0, name_len_q}) begin
          pos_d = 16'd0;
          if (kind_q == KIND_CHAT && text_len_q != 16'd0) begin
            phase_d = PH_TEXT;
          end else begin
            frame_end = 1'b1;
            phase_d   = PH_TYPE;
          end
        end
      end
      PH_TEXT: begin
        role   = ROLE_TEXT;
        offset = pos_q;
        pos_d  = pos_inc;
        if (pos_inc >= text_len_q) begin
          frame_end = 1'b1;
          pos_d     = 16'd0;
          phase_d   = PH_TYPE;
        end
      end
      PH_MAXNAME: begin
        role    = ROLE_MAX_NAME;
        phase_d = PH_MAXHI;
      end
      PH_MAXHI: begin
        role    = ROLE_MAX_HI;
        phase_d = PH_MAXLO;
      end
      PH_MAXLO: begin
        role      = ROLE_MAX_LO;
        frame_end = 1'b1;
        phase_d   = PH_TYPE;
      end
      default: begin
        kind_d = byte_i;
        pos_d  = 16'd0;
        if (byte_i == KIND_BYE) begin
          phase_d = PH_REASON;
        end else if (byte_i == KIND_HELLO || byte_i == KIND_CHAT) begin
          phase_d = PH_NAMELEN;
        end else if (byte_i == KIND_WELCOME) begin
          phase_d = PH_MAXNAME;
        end else begin
          role      = ROLE_UNKNOWN;
          frame_end = 1'b1;
          phase_d   = PH_TYPE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_TYPE;
      kind_q     <= 8'd0;
      name_len_q <= 8'd0;
      text_len_q <= 16'd0;
      pos_q      <= 16'd0;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      kind_q     <= kind_d;
      name_len_q <= name_len_d;
      text_len_q <= text_len_d;
      pos_q      <= pos_d;
    end
  end

  assign result_o.byte_role    = role;
  assign result_o.byte_value   = byte_i;
  assign result_o.frame_kind   = kind_d;
  assign result_o.field_offset = offset;
  assign result_o.frame_end    = frame_end;

endmodule

### rtl/core/cmdf_out_stage.sv
// ----------------------------------------------------------------------------
// Chat message deframer output stage
// Result register that holds each tagged byte until the consumer takes it.
// ----------------------------------------------------------------------------
module cmdf_out_stage
  import cmdf_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  output logic    take_o,
  input  result_t result_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t result_q;
  logic    space;

  assign space  = !valid_q || out_ready_i;
  assign take_o = valid_i && space;

  always_comb begin
    valid_d = valid_q;
    if (space) begin
      valid_d = valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

### rtl/core/chat_message_deframer.sv
// ----------------------------------------------------------------------------
// Chat message deframer
// Tags every byte of a stream of back-to-back chat messages with its role.
// ----------------------------------------------------------------------------
// Each accepted byte yields exactly one tagged item. Bytes pass through an
// input register, a single pass of parsing logic and a result register, so
// one byte is accepted every cycle as long as the consumer keeps taking
// results; throughput is set only by out_ready_i. Unknown type bytes are
// reported as one-byte frames and parsing resumes at the next byte.
module chat_message_deframer
  import cmdf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  stream_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  byte_role_o,
  output logic [7:0]  byte_value_o,
  output logic [7:0]  frame_kind_o,
  output logic [15:0] field_offset_o,
  output logic        frame_end_o
);

`include "chat_message_deframer_defines.svh"

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       take;
  result_t    parsed;
  result_t    result;

  cmdf_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .stream_byte_i (stream_byte_i),
    .take_i        (take),
    .valid_o       (s1_valid),
    .byte_o        (s1_byte)
  );

  cmdf_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (take),
    .byte_i   (s1_byte),
    .result_o (parsed)
  );

  cmdf_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s1_valid),
    .take_o      (take),
    .result_i    (parsed),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

  assign byte_role_o    = result.byte_role;
  assign byte_value_o   = result.byte_value;
  assign frame_kind_o   = result.frame_kind;
  assign field_offset_o = result.field_offset;
  assign frame_end_o    = result.frame_end;

  `CMDF_ASSERT_IMPL(a_unknown_ends, clk_i, rst_ni,
      out_valid_o && byte_role_o == ROLE_UNKNOWN, frame_end_o,
      "unknown type item does not end its frame")
  `CMDF_ASSERT_IMPL(a_offset_zero, clk_i, rst_ni,
      out_valid_o && byte_role_o != ROLE_NAME && byte_role_o != ROLE_TEXT,
      field_offset_o == 16'd0, "nonzero offset outside a name or text field")
  `CMDF_ASSERT_IMPL(a_type_kind, clk_i, rst_ni,
      out_valid_o && (byte_role_o == ROLE_TYPE || byte_role_o == ROLE_UNKNOWN),
      frame_kind_o == byte_value_o, "type item frame kind differs from its byte")
  `CMDF_ASSERT_IMPL(a_no_stall, clk_i, rst_ni,
      !out_valid_o || out_ready_i, in_ready_o,
      "input stalled while the result side can move")

endmodule

### verif/tb_chat_message_deframer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Chat message deframer testbench
// Drives a byte stream of bye, hello, welcome, chat and unknown frames into
// the deframer, with truncated frames and random noise mixed in. A byte-level
// parser model in the testbench tags each accepted byte, and a monitor checks
// every tagged item against that expectation. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_chat_message_deframer;
  import cmdf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 1000;

  typedef enum logic [3:0] {
    AT_TYPE, AT_REASON, AT_NAME_LEN, AT_TLEN_HI, AT_TLEN_LO,
    AT_NAME, AT_TEXT, AT_MAX_NAME, AT_MAX_HI, AT_MAX_LO
  } parse_phase_e;

  typedef struct {
    parse_phase_e phase;
    logic [7:0]   kind;
    logic [7:0]   name_len;
    logic [15:0]  text_len;
    logic [15:0]  pos;
  } parser_state_t;

  typedef struct {
    logic [7:0] data;
    bit         drain_first;
    bit         steady;
  } stream_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  stream_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [3:0]  byte_role_o;
  logic [7:0]  byte_value_o;
  logic [7:0]  frame_kind_o;
  logic [15:0] field_offset_o;
  logic        frame_end_o;

  stream_item_t  pending_bytes[$];
  result_t       expected_tags[$];
  logic [7:0]    frame_bytes[$];
  parser_state_t gen_parser;
  parser_state_t dut_parser;
  bit            gen_drain;
  bit            gen_steady;
  bit            steady_now;
  int            error_count;
  int            cycle_count;
  int            checked_count;
  int            frame_count;
  int            chat_count;
  int            broken_count;

  chat_message_deframer uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .stream_byte_i  (stream_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .byte_role_o    (byte_role_o),
    .byte_value_o   (byte_value_o),
    .frame_kind_o   (frame_kind_o),
    .field_offset_o (field_offset_o),
    .frame_end_o    (frame_end_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Parser model: tags one byte and advances the frame state.
  function automatic result_t tag_byte(inout parser_state_t st, input logic [7:0] b);
    result_t r;
    r.byte_role    = ROLE_TYPE;
    r.byte_value   = b;
    r.field_offset = 16'd0;
    r.frame_end    = 1'b0;
    case (st.phase)
      AT_REASON: begin
        r.byte_role = ROLE_REASON;
        r.frame_end = 1'b1;
        st.phase    = AT_TYPE;
      end
      AT_NAME_LEN: begin
        r.byte_role = ROLE_NAME_LEN;
        st.name_len = b;
        st.pos      = 16'd0;
        if (st.kind == KIND_CHAT) begin
          st.phase = AT_TLEN_HI;
        end else if (b == 8'd0) begin
          r.frame_end = 1'b1;
          st.phase    = AT_TYPE;
        end else begin
          st.phase = AT_NAME;
        end
      end
      AT_TLEN_HI: begin
        r.byte_role = ROLE_TLEN_HI;
        st.text_len = {b, 8'h00};
        st.phase    = AT_TLEN_LO;
      end
      AT_TLEN_LO: begin
        r.byte_role = ROLE_TLEN_LO;
        st.text_len = st.text_len | {8'h00, b};
        st.pos      = 16'd0;
        if (st.name_len != 8'd0) begin
          st.phase = AT_NAME;
        end else if (st.text_len != 16'd0) begin
          st.phase = AT_TEXT;
        end else begin
          r.frame_end = 1'b1;
          st.phase    = AT_TYPE;
        end
      end
      AT_NAME: begin
        r.byte_role    = ROLE_NAME;
        r.field_offset = st.pos;
        st.pos         = st.pos + 16'd1;
        if (st.pos >= {8'h00, st.name_len}) begin
          st.pos = 16'd0;
          if (st.kind == KIND_CHAT && st.text_len != 16'd0) begin
            st.phase = AT_TEXT;
          end else begin
            r.frame_end = 1'b1;
            st.phase    = AT_TYPE;
          end
        end
      end
      AT_TEXT: begin
        r.byte_role    = ROLE_TEXT;
        r.field_offset = st.pos;
        st.pos         = st.pos + 16'd1;
        if (st.pos >= st.text_len) begin
          r.frame_end = 1'b1;
          st.pos      = 16'd0;
          st.phase    = AT_TYPE;
        end
      end
      AT_MAX_NAME: begin
        r.byte_role = ROLE_MAX_NAME;
        st.phase    = AT_MAX_HI;
      end
      AT_MAX_HI: begin
        r.byte_role = ROLE_MAX_HI;
        st.phase    = AT_MAX_LO;
      end
      AT_MAX_LO: begin
        r.byte_role = ROLE_MAX_LO;
        r.frame_end = 1'b1;
        st.phase    = AT_TYPE;
      end
      default: begin
        st.kind = b;
        st.pos  = 16'd0;
        if (b == KIND_BYE) begin
          st.phase = AT_REASON;
        end else if (b == KIND_HELLO || b == KIND_CHAT) begin
          st.phase = AT_NAME_LEN;
        end else if (b == KIND_WELCOME) begin
          st.phase = AT_MAX_NAME;
        end else begin
          r.byte_role = ROLE_UNKNOWN;
          r.frame_end = 1'b1;
          st.phase    = AT_TYPE;
        end
      end
    endcase
    r.frame_kind = st.kind;
    return r;
  endfunction

  function automatic void queue_byte(input logic [7:0] b);
    stream_item_t item;
    void'(tag_byte(gen_parser, b));
    item.data        = b;
    item.drain_first = gen_drain;
    item.steady      = gen_steady;
    pending_bytes.push_back(item);
    gen_drain = 1'b0;
  endfunction

  function automatic void compose_frame(input logic [7:0] kind, input int name_n,
                                        input int text_n);
    frame_bytes.delete();
    frame_bytes.push_back(kind);
    if (kind == KIND_BYE) begin
      frame_bytes.push_back(8'($urandom_range(0, 255)));
    end else if (kind == KIND_HELLO || kind == KIND_CHAT) begin
      frame_bytes.push_back(8'(name_n));
      if (kind == KIND_CHAT) begin
        frame_bytes.push_back(8'(text_n >> 8));
        frame_bytes.push_back(8'(text_n));
      end
      repeat (name_n) frame_bytes.push_back(8'($urandom_range(0, 255)));
      if (kind == KIND_CHAT) begin
        repeat (text_n) frame_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end else if (kind == KIND_WELCOME) begin
      repeat (3) frame_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void emit_frame(input int count);
    for (int i = 0; i < count; i++) queue_byte(frame_bytes[i]);
    frame_count++;
    if (frame_bytes[0] == KIND_CHAT) chat_count++;
  endfunction

  function automatic int pick_length(input int longest);
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return $urandom_range(longest / 2, longest);
    if (r < 15) return $urandom_range(7, 20);
    return $urandom_range(0, 6);
  endfunction

  function automatic logic [7:0] pick_unknown_kind();
    if ($urandom_range(0, 9) == 0) return 8'd1;
    return 8'($urandom_range(5, 255));
  endfunction

  function automatic logic [7:0] pick_kind();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return KIND_BYE;
    if (r < 4) return KIND_HELLO;
    if (r < 6) return KIND_WELCOME;
    if (r < 9) return KIND_CHAT;
    return pick_unknown_kind();
  endfunction

  // A random byte, except that a high text length byte stays small so that a
  // stray chat header cannot swallow tens of thousands of bytes.
  function automatic logic [7:0] stray_byte();
    if (gen_parser.phase == AT_TLEN_HI) return 8'($urandom_range(0, 1));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void resync();
    while (gen_parser.phase != AT_TYPE) queue_byte(stray_byte());
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    error_count++;
    $display("ERROR @%0t item %0d: %s got %0h expected %0h",
             $time, checked_count, what, got, want);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    stream_item_t nxt;
    bit           go;
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      stream_byte_i <= 8'h00;
      steady_now    <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_tags.push_back(tag_byte(dut_parser, stream_byte_i));
      end
      if (!in_valid_i || in_ready_o) begin
        go = 1'b0;
        if (pending_bytes.size() > 0) begin
          nxt = pending_bytes[0];
          steady_now <= nxt.steady;
          if (nxt.drain_first && expected_tags.size() > 0) begin
            go = 1'b0;
          end else if (!nxt.steady && $urandom_range(0, 99) < 14) begin
            go = 1'b0;
          end else begin
            go = 1'b1;
          end
        end
        if (go) begin
          void'(pending_bytes.pop_front());
          in_valid_i    <= 1'b1;
          stream_byte_i <= nxt.data;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_tags.size() == 0) begin
          report_mismatch("unexpected item, byte", {8'h00, byte_value_o}, 16'h0);
        end else begin
          want = expected_tags.pop_front();
          if (byte_role_o !== want.byte_role)
            report_mismatch("byte_role", {12'h0, byte_role_o}, {12'h0, want.byte_role});
          if (byte_value_o !== want.byte_value)
            report_mismatch("byte_value", {8'h0, byte_value_o}, {8'h0, want.byte_value});
          if (frame_kind_o !== want.frame_kind)
            report_mismatch("frame_kind", {8'h0, frame_kind_o}, {8'h0, want.frame_kind});
          if (field_offset_o !== want.field_offset)
            report_mismatch("field_offset", field_offset_o, want.field_offset);
          if (frame_end_o !== want.frame_end)
            report_mismatch("frame_end", {15'h0, frame_end_o}, {15'h0, want.frame_end});
        end
        checked_count++;
      end
      out_ready_i <= steady_now || ($urandom_range(0, 99) >= 14);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d items outstanding.",
               cycle_count, expected_tags.size());
      $display("FAIL chat_message_deframer");
      $finish;
    end
  end

  initial begin
    int start_size;
    int r;
    int cut;
    logic [7:0] kind;
    gen_parser = '{AT_TYPE, 8'h00, 8'h00, 16'h0000, 16'h0000};
    dut_parser = gen_parser;

    // Directed frames: field extremes, empty names and texts, unknown types.
    compose_frame(KIND_BYE, 0, 0);
    frame_bytes[1] = 8'hFF;
    emit_frame(frame_bytes.size());
    compose_frame(KIND_HELLO, 0, 0);
    emit_frame(frame_bytes.size());
    compose_frame(KIND_HELLO, 1, 0);
    emit_frame(frame_bytes.size());
    compose_frame(KIND_WELCOME, 0, 0);
    frame_bytes[1] = 8'hFF;
    frame_bytes[2] = 8'hFF;
    frame_bytes[3] = 8'h00;
    emit_frame(frame_bytes.size());
    compose_frame(KIND_CHAT, 0, 0);
    emit_frame(frame_bytes.size());
    compose_frame(KIND_CHAT, 0, 1);
    emit_frame(frame_bytes.size());
    compose_frame(KIND_CHAT, 1, 0);
    emit_frame(frame_bytes.size());
    compose_frame(8'd1, 0, 0);
    emit_frame(1);
    compose_frame(8'd5, 0, 0);
    emit_frame(1);
    compose_frame(8'd255, 0, 0);
    emit_frame(1);

    // Random part: mostly well-formed frames, some noise and cut frames.
    gen_drain  = 1'b1;
    start_size = pending_bytes.size();
    while (pending_bytes.size() - start_size < RANDOM_ITEMS) begin
      if (pending_bytes.size() - start_size >= 450 && pending_bytes.size() - start_size < 460)
        gen_drain = 1'b1;
      gen_steady = (pending_bytes.size() - start_size >= 550) &&
                   (pending_bytes.size() - start_size < 750);
      r = $urandom_range(0, 99);
      if (r < 80) begin
        kind = pick_kind();
        compose_frame(kind, pick_length(255), pick_length(400));
        emit_frame(frame_bytes.size());
      end else if (r < 90) begin
        repeat ($urandom_range(1, 6)) queue_byte(stray_byte());
        resync();
      end else begin
        do kind = pick_kind(); while (kind != KIND_BYE && kind != KIND_HELLO &&
                                      kind != KIND_WELCOME && kind != KIND_CHAT);
        compose_frame(kind, $urandom_range(1, 8), $urandom_range(0, 8));
        cut = $urandom_range(1, frame_bytes.size() - 1);
        emit_frame(cut);
        resync();
        broken_count++;
      end
    end
    gen_steady = 1'b0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_bytes.size() > 0 || in_valid_i) @(posedge clk_i);
    while (expected_tags.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Covered %0d frames (%0d chat, %0d cut short) plus noise bytes.",
             frame_count, chat_count, broken_count);
    $display("Checked %0d tagged items with %0d mismatches.", checked_count, error_count);
    if (error_count == 0) begin
      $display("PASS chat_message_deframer");
    end else begin
      $display("FAIL chat_message_deframer");
    end
    $finish;
  end

endmodule
